FILE: rtl/core/fqks_pkg.sv
// shared types, widths and codes of the fifo queue with key search
package fqks_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned ValW         = 8;
  localparam int unsigned OpW          = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountW       = 5;
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 80;

  typedef enum logic [OpW-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_LOOK = 2'd2,
    OP_UPD  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_SCAN = 4'b0100,
    S_TAIL = 4'b1000
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [KeyW-1:0]     key;
    logic [ValW-1:0]     value;
    logic                has_next;
    logic [KeyW-1:0]     next_key;
  } res_t;

  function automatic res_t mk_res(status_e st, logic [KeyW-1:0] k, logic [ValW-1:0] v,
                                  logic hn, logic [KeyW-1:0] nk);
    res_t r;
    r.status   = st;
    r.key      = k;
    r.value    = v;
    r.has_next = hn;
    r.next_key = nk;
    return r;
  endfunction

endpackage

FILE: rtl/core/fifo_queue_key_search_top.sv
// bounded fifo of key/value entries with dequeue, lookup and update by key
//
// input stream: tuser carries the opcode (enqueue, dequeue, lookup, update),
// tdata carries key and value. output stream: tuser carries the status,
// tdata the entry fields and count, tlast marks the final result of a request.
// one request is worked on at a time; s_axis_tready is high while the block
// is free. enqueue and the empty or full cases go straight to the tail state,
// which loads the output register; dequeue first takes the head entry in the
// dequeue state. lookup walks the stored entries from head to tail, update
// only up to its first match, one store read per cycle while the output is
// not stalled; a lookup gives one result per matching entry, an update one.
// results wait in an output register, so a stalled receiver holds the
// current result stable and the walk pauses until it is taken.
// reset empties the queue at once (head, tail and count to zero); the
// stores themselves are not cleared since only occupied entries are read.
module fifo_queue_key_search_top #(
  parameter int unsigned DEPTH = fqks_pkg::DepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // key [31:0], value [39:32]
  input  logic [fqks_pkg::InDataW-1:0] s_axis_tdata_i,
  // opcode [1:0]
  input  logic [fqks_pkg::OpW-1:0]     s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // key_out [31:0], value_out [39:32], has_next [40], next_key [72:41],
  // entry_count [77:73], zero [79:78]
  output logic [fqks_pkg::OutDataW-1:0] m_axis_tdata_o,
  // status [1:0]
  output logic [fqks_pkg::StatusW-1:0] m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import fqks_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned PadW = OutDataW - (2 * KeyW + ValW + 1 + CountW);

  logic [KeyW-1:0] key_mem [DEPTH];
  logic [ValW-1:0] val_mem [DEPTH];
  logic [KeyW-1:0] rkey_q;
  logic [ValW-1:0] rval_q;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] iss_pos_q, iss_pos_d, rd_pos_q, rd_pos_d;
  logic [IdxW-1:0] iss_slot_q, iss_slot_d, rd_slot_q, rd_slot_d;
  logic            pend_v_q, pend_v_d;
  logic [KeyW-1:0] pend_key_q, pend_key_d;
  logic [ValW-1:0] pend_val_q, pend_val_d;
  logic            held_v_q, held_v_d;
  res_t            held_q, held_d;
  logic            out_v_q, out_v_d;
  res_t            out_q, out_d;
  logic            out_last_q, out_last_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  logic            mem_rd_en, key_we, val_we;
  logic [IdxW-1:0] mem_rd_addr, mem_wr_addr;
  logic [ValW-1:0] mem_wr_val;

  logic            s_accept, out_free, step_ok, rd_last, is_upd, match, occ_full, occ_empty;
  op_e             in_op;
  logic [KeyW-1:0] in_key;
  logic [ValW-1:0] in_val;

  function automatic logic [IdxW-1:0] inc_idx(logic [IdxW-1:0] i);
    return (i == IdxW'(DEPTH - 1)) ? '0 : i + IdxW'(1);
  endfunction

  assign in_op     = op_e'(s_axis_tuser_i);
  assign in_key    = s_axis_tdata_i[KeyW-1:0];
  assign in_val    = s_axis_tdata_i[KeyW+ValW-1:KeyW];
  assign s_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_v_q || m_axis_tready_i;
  assign step_ok   = out_free || !(held_v_q && pend_v_q);
  assign rd_last   = (rd_pos_q + CntW'(1)) == occ_q;
  assign is_upd    = op_q == OP_UPD;
  assign match     = rkey_q == key_q;
  assign occ_full  = occ_q == CntW'(DEPTH);
  assign occ_empty = occ_q == '0;

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_cnt_q, out_q.next_key, out_q.has_next,
                            out_q.value, out_q.key};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    iss_pos_d   = iss_pos_q;
    iss_slot_d  = iss_slot_q;
    rd_pos_d    = rd_pos_q;
    rd_slot_d   = rd_slot_q;
    pend_v_d    = pend_v_q;
    pend_key_d  = pend_key_q;
    pend_val_d  = pend_val_q;
    held_v_d    = held_v_q;
    held_d      = held_q;
    out_v_d     = out_v_q && !m_axis_tready_i;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_cnt_d   = out_cnt_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    mem_wr_addr = tail_q;
    mem_wr_val  = in_val;

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          op_d     = in_op;
          key_d    = in_key;
          val_d    = in_val;
          pend_v_d = 1'b0;
          held_v_d = 1'b0;
          state_d  = S_TAIL;
          unique case (in_op)
            OP_ENQ: begin
              held_v_d = 1'b1;
              if (occ_full) begin
                held_d = mk_res(ST_FULL, in_key, in_val, 1'b0, '0);
              end else begin
                key_we = 1'b1;
                val_we = 1'b1;
                tail_d = inc_idx(tail_q);
                occ_d  = occ_q + CntW'(1);
                held_d = mk_res(ST_OK, in_key, in_val, 1'b0, '0);
              end
            end
            OP_DEQ: begin
              if (occ_empty) begin
                held_v_d = 1'b1;
                held_d   = mk_res(ST_EMPTY, '0, '0, 1'b0, '0);
              end else begin
                mem_rd_en = 1'b1;
                state_d   = S_DEQ;
              end
            end
            OP_LOOK, OP_UPD: begin
              if (occ_empty) begin
                if (in_op == OP_LOOK) begin
                  held_v_d = 1'b1;
                  held_d   = mk_res(ST_EMPTY, '0, '0, 1'b0, '0);
                end
              end else begin
                mem_rd_en  = 1'b1;
                iss_pos_d  = CntW'(1);
                iss_slot_d = inc_idx(head_q);
                rd_pos_d   = '0;
                rd_slot_d  = head_q;
                state_d    = S_SCAN;
              end
            end
            default: state_d = S_TAIL;
          endcase
        end
      end

      S_DEQ: begin
        held_v_d = 1'b1;
        held_d   = mk_res(ST_OK, rkey_q, rval_q, 1'b0, '0);
        head_d   = inc_idx(head_q);
        occ_d    = occ_q - CntW'(1);
        state_d  = S_TAIL;
      end

      S_SCAN: begin
        if (step_ok) begin
          if (iss_pos_q < occ_q) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = iss_slot_q;
            iss_pos_d   = iss_pos_q + CntW'(1);
            iss_slot_d  = inc_idx(iss_slot_q);
            rd_pos_d    = iss_pos_q;
            rd_slot_d   = iss_slot_q;
          end
          // previous match now knows the key that follows it
          if (pend_v_q) begin
            held_v_d = 1'b1;
            held_d   = mk_res(ST_OK, pend_key_q, pend_val_q, 1'b1, rkey_q);
            if (held_v_q) begin
              out_v_d    = 1'b1;
              out_d      = held_q;
              out_last_d = 1'b0;
              out_cnt_d  = CountW'(occ_q);
            end
          end
          if (is_upd && pend_v_q) begin
            pend_v_d = 1'b0;
            state_d  = S_TAIL;
          end else begin
            pend_v_d   = match;
            pend_key_d = rkey_q;
            pend_val_d = is_upd ? val_q : rval_q;
            if (is_upd && match) begin
              val_we      = 1'b1;
              mem_wr_addr = rd_slot_q;
              mem_wr_val  = val_q;
            end
            if (rd_last) begin
              state_d = S_TAIL;
            end
          end
        end
      end

      S_TAIL: begin
        if (pend_v_q) begin
          if (!held_v_q) begin
            held_v_d = 1'b1;
            held_d   = mk_res(ST_OK, pend_key_q, pend_val_q, 1'b0, '0);
            pend_v_d = 1'b0;
          end else if (out_free) begin
            out_v_d    = 1'b1;
            out_d      = held_q;
            out_last_d = 1'b0;
            out_cnt_d  = CountW'(occ_q);
            held_d     = mk_res(ST_OK, pend_key_q, pend_val_q, 1'b0, '0);
            pend_v_d   = 1'b0;
          end
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_cnt_d  = CountW'(occ_q);
          out_d      = held_v_q ? held_q : mk_res(ST_NOTFOUND, key_q, '0, 1'b0, '0);
          held_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[mem_wr_addr] <= in_key;
    end
    if (val_we) begin
      val_mem[mem_wr_addr] <= mem_wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      rkey_q <= key_mem[mem_rd_addr];
      rval_q <= val_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      pend_v_q <= 1'b0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      pend_v_q <= pend_v_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    iss_pos_q  <= iss_pos_d;
    iss_slot_q <= iss_slot_d;
    rd_pos_q   <= rd_pos_d;
    rd_slot_q  <= rd_slot_d;
    pend_key_q <= pend_key_d;
    pend_val_q <= pend_val_d;
    held_q     <= held_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    out_cnt_q  <= out_cnt_d;
  end

endmodule

FILE: rtl/core/fqks_checker.sv
// port-level assertions for the fifo queue with key search, bound to the top
module fqks_checker #(
  parameter int unsigned DEPTH = fqks_pkg::DepthDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [fqks_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [fqks_pkg::StatusW-1:0]  m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);
  import fqks_pkg::*;

  localparam logic [CountW-1:0] FullCnt = CountW'(DEPTH);

  logic [CountW-1:0] cnt;
  logic              hn;

  assign cnt = m_axis_tdata_o[2*KeyW+ValW+CountW:2*KeyW+ValW+1];
  assign hn  = m_axis_tdata_o[KeyW+ValW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL) |-> cnt == FullCnt && m_axis_tlast_o)
    else $error("full status with wrong count");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY) |-> cnt == '0 && m_axis_tlast_o)
    else $error("empty status with nonzero count");

  a_next_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && hn |-> m_axis_tuser_o == ST_OK)
    else $error("has_next on a failed request");

endmodule

bind fifo_queue_key_search_top fqks_checker #(.DEPTH(DEPTH)) u_fqks_checker (.*);
